FILE: hdl/vlfs_pkg.sv
`default_nettype none

package vlfs_pkg;

    // data word width
    localparam int WORD_W = 32;

    // default sizes
    localparam int DEF_WORD_DEPTH    = 1024;
    localparam int DEF_FRAME_DEPTH   = 64;
    localparam int DEF_MAX_FRAME_LEN = 64;

    // input action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_BASE,
        S_STREAM,
        S_MOVE
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/variable_length_frame_stack_top.sv
// channel   | ports                          | beat taken when
// ----------+--------------------------------+------------------------------
// command   | start, busy, action, word,     | start high and busy low at a
//           | frame_end                      | rising clk edge
// result    | valid, word_out, run_last,     | every cycle valid is high
//           | stack_empty                    | (receiver cannot stall)
//
// push: busy stays low, so pushes can arrive back to back.
// pop of an empty stack: result in the next cycle, busy stays low.
// pop of a frame of n words with m words in the open frame: busy through
// the base read, the stream and the move; the single-read-port word memory
// streams one word per cycle and then slides the open frame down one word per cycle.
// rst_n is asynchronous, active low; memories come up undefined, no clearing pass.
`default_nettype none

module variable_length_frame_stack_top #(
    parameter int WORD_DEPTH    = vlfs_pkg::DEF_WORD_DEPTH,
    parameter int FRAME_DEPTH   = vlfs_pkg::DEF_FRAME_DEPTH,
    parameter int MAX_FRAME_LEN = vlfs_pkg::DEF_MAX_FRAME_LEN
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic signed [vlfs_pkg::WORD_W-1:0] word,
    input  logic                              frame_end,
    output logic                              valid,
    output logic signed [vlfs_pkg::WORD_W-1:0] word_out,
    output logic                              run_last,
    output logic                              stack_empty
);

    localparam int AW  = $clog2(WORD_DEPTH);
    localparam int ACW = $clog2(WORD_DEPTH + 1);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int LW  = $clog2(MAX_FRAME_LEN + 1);
    localparam int DW  = vlfs_pkg::WORD_W;

    // memories
    logic [DW-1:0] word_mem [WORD_DEPTH];
    logic [AW-1:0] base_mem [FRAME_DEPTH];

    logic          wm_we;
    logic [AW-1:0] wm_waddr;
    logic [DW-1:0] wm_wdata;
    logic          wm_re;
    logic [AW-1:0] wm_raddr;
    logic [DW-1:0] wm_rdata;

    logic           bs_we;
    logic [FAW-1:0] bs_waddr;
    logic [AW-1:0]  bs_wdata;
    logic           bs_re;
    logic [FAW-1:0] bs_raddr;
    logic [AW-1:0]  bs_rdata;

    // control registers
    vlfs_pkg::state_t state_reg, state_next;
    logic [FCW-1:0]   count_reg, count_next;
    logic [ACW-1:0]   fill_reg, fill_next;
    logic [LW-1:0]    open_reg, open_next;
    logic [LW-1:0]    left_reg, left_next;
    logic             valid_reg, valid_next;

    // working and result registers
    logic [AW-1:0]  base_reg, base_next;
    logic [ACW-1:0] ptr_reg, ptr_next;
    logic [ACW-1:0] end_reg, end_next;
    logic [DW-1:0]  word_out_reg, word_out_next;
    logic           run_last_reg, run_last_next;
    logic           empty_reg, empty_next;

    // push helpers
    logic           accept;
    logic           stack_full;
    logic           can_store;
    logic [LW-1:0]  open_sum;
    logic [ACW-1:0] open_base;
    logic [FCW-1:0] count_m1;
    logic           last_beat;

    assign accept     = start && (state_reg == vlfs_pkg::S_IDLE);
    assign stack_full = (count_reg == FCW'(FRAME_DEPTH));
    assign can_store  = (fill_reg < ACW'(WORD_DEPTH)) && (open_reg < LW'(MAX_FRAME_LEN));
    assign open_sum   = open_reg + LW'(can_store);
    assign open_base  = fill_reg - ACW'(open_reg);
    assign count_m1   = count_reg - FCW'(1);
    assign last_beat  = (left_reg == LW'(1));

    // word memory
    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            word_mem[wm_waddr] <= wm_wdata;
        end
        if (wm_re)
        begin
            wm_rdata <= word_mem[wm_raddr];
        end
    end

    // frame base memory
    always_ff @(posedge clk)
    begin
        if (bs_we)
        begin
            base_mem[bs_waddr] <= bs_wdata;
        end
        if (bs_re)
        begin
            bs_rdata <= base_mem[bs_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vlfs_pkg::S_IDLE:
            begin
                if (accept && (action == vlfs_pkg::ACT_POP) && (count_reg != '0))
                begin
                    state_next = vlfs_pkg::S_BASE;
                end
            end
            vlfs_pkg::S_BASE:
            begin
                state_next = vlfs_pkg::S_STREAM;
            end
            vlfs_pkg::S_STREAM:
            begin
                if (last_beat)
                begin
                    state_next = (open_reg != '0) ? vlfs_pkg::S_MOVE : vlfs_pkg::S_IDLE;
                end
            end
            vlfs_pkg::S_MOVE:
            begin
                if (last_beat)
                begin
                    state_next = vlfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vlfs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        fill_next     = fill_reg;
        open_next     = open_reg;
        left_next     = left_reg;
        valid_next    = 1'b0;
        base_next     = base_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        word_out_next = word_out_reg;
        run_last_next = run_last_reg;
        empty_next    = empty_reg;
        wm_we         = 1'b0;
        wm_waddr      = fill_reg[AW-1:0];
        wm_wdata      = $unsigned(word);
        wm_re         = 1'b0;
        wm_raddr      = ptr_reg[AW-1:0];
        bs_we         = 1'b0;
        bs_waddr      = count_reg[FAW-1:0];
        bs_wdata      = open_base[AW-1:0];
        bs_re         = 1'b0;
        bs_raddr      = count_m1[FAW-1:0];

        case (state_reg)
            vlfs_pkg::S_IDLE:
            begin
                if (accept && (action == vlfs_pkg::ACT_PUSH))
                begin
                    // append to the open frame, commit on frame_end
                    if (!stack_full)
                    begin
                        if (can_store)
                        begin
                            wm_we     = 1'b1;
                            fill_next = fill_reg + ACW'(1);
                            open_next = open_sum;
                        end
                        if (frame_end && (open_sum != '0))
                        begin
                            bs_we      = 1'b1;
                            count_next = count_reg + FCW'(1);
                            open_next  = '0;
                        end
                    end
                end
                else if (accept)
                begin
                    if (count_reg == '0)
                    begin
                        // empty pop answers at once
                        valid_next    = 1'b1;
                        word_out_next = '0;
                        run_last_next = 1'b1;
                        empty_next    = 1'b1;
                    end
                    else
                    begin
                        bs_re    = 1'b1;
                        end_next = open_base;
                    end
                end
            end
            vlfs_pkg::S_BASE:
            begin
                // top frame base is back, start the word stream
                wm_re     = 1'b1;
                wm_raddr  = bs_rdata;
                base_next = bs_rdata;
                ptr_next  = ACW'(bs_rdata) + ACW'(1);
                left_next = LW'(end_reg - ACW'(bs_rdata));
            end
            vlfs_pkg::S_STREAM:
            begin
                // one word of the frame per cycle
                valid_next    = 1'b1;
                word_out_next = wm_rdata;
                run_last_next = last_beat;
                empty_next    = 1'b0;
                left_next     = left_reg - LW'(1);
                if (!last_beat)
                begin
                    wm_re    = 1'b1;
                    ptr_next = ptr_reg + ACW'(1);
                end
                else if (open_reg != '0)
                begin
                    // slide the open frame down over the removed one
                    wm_re     = 1'b1;
                    wm_raddr  = end_reg[AW-1:0];
                    ptr_next  = end_reg + ACW'(1);
                    left_next = open_reg;
                end
                else
                begin
                    fill_next  = ACW'(base_reg);
                    count_next = count_m1;
                end
            end
            vlfs_pkg::S_MOVE:
            begin
                // read ahead, write behind; source always above target
                wm_we     = 1'b1;
                wm_waddr  = base_reg;
                wm_wdata  = wm_rdata;
                base_next = base_reg + AW'(1);
                left_next = left_reg - LW'(1);
                if (!last_beat)
                begin
                    wm_re    = 1'b1;
                    ptr_next = ptr_reg + ACW'(1);
                end
                else
                begin
                    fill_next  = ACW'(base_reg) + ACW'(1);
                    count_next = count_m1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vlfs_pkg::S_IDLE;
            count_reg <= '0;
            fill_reg  <= '0;
            open_reg  <= '0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            open_reg  <= open_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        word_out_reg <= word_out_next;
        run_last_reg <= run_last_next;
        empty_reg    <= empty_next;
    end

    assign busy        = (state_reg != vlfs_pkg::S_IDLE);
    assign valid       = valid_reg;
    assign word_out    = $signed(word_out_reg);
    assign run_last    = run_last_reg;
    assign stack_empty = empty_reg;

endmodule

`default_nettype wire

FILE: hdl/vlfs_checker.sv
`default_nettype none

module vlfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        valid,
    input logic [31:0] word_out,
    input logic        run_last,
    input logic        stack_empty
);

    // an empty pop gives a single zero beat
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && stack_empty |-> run_last && (word_out == 32'd0))
        else $error("empty pop beat malformed");

    // a push never produces a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == vlfs_pkg::ACT_PUSH) |=> !valid)
        else $error("beat after push");

    // a pop either answers empty at once or goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == vlfs_pkg::ACT_POP) |=> (valid && stack_empty) || busy)
        else $error("pop neither answered nor started");

    // frame words stream without gaps until the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !run_last |=> valid && !stack_empty)
        else $error("gap in frame stream");

endmodule

bind variable_length_frame_stack_top vlfs_checker u_vlfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .valid       (valid),
    .word_out    (word_out),
    .run_last    (run_last),
    .stack_empty (stack_empty)
);

`default_nettype wire

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW     = vlfs_pkg::WORD_W;
    localparam int WDEPTH = vlfs_pkg::DEF_WORD_DEPTH;
    localparam int FDEPTH = vlfs_pkg::DEF_FRAME_DEPTH;
    localparam int MAXLEN = vlfs_pkg::DEF_MAX_FRAME_LEN;
    localparam int ITEMS  = 220;
    localparam int DRAIN_CYCLES = 4 + 2 * MAXLEN + 20;

    // one result beat of a pop
    typedef struct packed {
        logic signed [DW-1:0] data;
        logic                 last;
        logic                 empty;
    } pop_beat_t;

    // tracks the frame stack and checks the words it pops
    class frame_stack_scoreboard;
        logic signed [DW-1:0] words [WDEPTH];
        int unsigned bases [FDEPTH];
        int unsigned frames;
        int unsigned fill;
        int unsigned open_len;
        pop_beat_t pending [$];
        int errors;
        int commands;
        int pops;
        int empty_pops;
        int beats;
        int dropped;

        // update the stack for an accepted command, queue the beats a pop gives
        function void note_command(logic act, logic signed [DW-1:0] w, logic fe);
            int unsigned base_a;
            int unsigned end_a;
            int unsigned len;
            pop_beat_t b;
            commands++;
            if (act == vlfs_pkg::ACT_PUSH)
            begin
                if (frames >= FDEPTH)
                begin
                    dropped++;
                    return;
                end
                if (fill < WDEPTH && open_len < MAXLEN)
                begin
                    words[fill] = w;
                    fill++;
                    open_len++;
                end
                else
                begin
                    dropped++;
                end
                if (fe && open_len > 0)
                begin
                    bases[frames] = fill - open_len;
                    frames++;
                    open_len = 0;
                end
                return;
            end
            pops++;
            if (frames == 0)
            begin
                b = '{data: '0, last: 1'b1, empty: 1'b1};
                pending.push_back(b);
                empty_pops++;
                return;
            end
            base_a = bases[frames - 1];
            end_a = fill - open_len;
            len = (end_a > base_a) ? end_a - base_a : 0;
            if (len > MAXLEN)
                len = MAXLEN;
            for (int unsigned i = 0; i < len; i++)
            begin
                b.data = (base_a + i < WDEPTH) ? words[base_a + i] : '0;
                b.last = (i + 1 == len);
                b.empty = 1'b0;
                pending.push_back(b);
            end
            if (len == 0)
            begin
                b = '{data: '0, last: 1'b1, empty: 1'b0};
                pending.push_back(b);
            end
            // open frame slides down onto the removed frame
            if (open_len > 0 && end_a > base_a && end_a + open_len <= WDEPTH)
                for (int unsigned k = 0; k < open_len; k++)
                    words[base_a + k] = words[end_a + k];
            fill = base_a + open_len;
            frames--;
        endfunction

        // compare one result beat with the oldest expected one
        function void check_beat(logic signed [DW-1:0] d, logic l, logic e);
            pop_beat_t want;
            beats++;
            if (pending.size() == 0)
            begin
                $error("result beat with no pop pending: %0d %0b %0b", d, l, e);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (d !== want.data)
            begin
                $error("word_out: expected %0d, got %0d", want.data, d);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("run_last: expected %0b, got %0b", want.last, l);
                errors++;
            end
            if (e !== want.empty)
            begin
                $error("stack_empty: expected %0b, got %0b", want.empty, e);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic signed [DW-1:0] word;
    logic                 frame_end;
    logic                 valid;
    logic signed [DW-1:0] word_out;
    logic                 run_last;
    logic                 stack_empty;

    frame_stack_scoreboard sb = new();
    bit no_idle;

    variable_length_frame_stack_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .word        (word),
        .frame_end   (frame_end),
        .valid       (valid),
        .word_out    (word_out),
        .run_last    (run_last),
        .stack_empty (stack_empty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_beat(word_out, run_last, stack_empty);
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // items still to send, at least one
    function automatic int room_left(input int want);
        int left;
        left = ITEMS - sb.commands;
        if (left < 1)
            left = 1;
        return (want < left) ? want : left;
    endfunction

    // drive one command beat and wait until it is taken
    task automatic send_cmd(input logic act, input logic signed [DW-1:0] w,
                            input logic fe);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        word      <= w;
        frame_end <= fe;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_command(act, w, fe);
    endtask

    task automatic push_words(input int n, input logic commit);
        for (int i = 0; i < n; i++)
            send_cmd(vlfs_pkg::ACT_PUSH, $urandom, commit && (i == n - 1));
    endtask

    task automatic pop_cmd();
        send_cmd(vlfs_pkg::ACT_POP, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // stimulus
    initial
    begin
        int sel;
        int len;
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = vlfs_pkg::ACT_PUSH;
        word      = '0;
        frame_end = 1'b0;
        no_idle   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, word extremes, nesting, pop with an open frame
        pop_cmd();
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h8000_0000, 1'b0);
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h7fff_ffff, 1'b0);
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h0000_0000, 1'b0);
        send_cmd(vlfs_pkg::ACT_PUSH, 32'hffff_ffff, 1'b0);
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h0000_0001, 1'b1);
        pop_cmd();
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h5555_5555, 1'b1);
        send_cmd(vlfs_pkg::ACT_PUSH, 32'haaaa_aaaa, 1'b0);
        push_words(2, 1'b1);
        push_words(2, 1'b0);
        pop_cmd();
        pop_cmd();
        pop_cmd();
        send_cmd(vlfs_pkg::ACT_PUSH, 32'h1234_5678, 1'b1);
        pop_cmd();
        pop_cmd();

        // frame cap, back to back, then pop it under an open frame
        no_idle = 1'b1;
        push_words(MAXLEN + 2, 1'b1);
        no_idle = 1'b0;
        push_words(3, 1'b0);
        pop_cmd();
        pop_cmd();

        // random frames, pops and loose words
        while (sb.commands < ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            sel = $urandom_range(0, 99);
            if (sb.frames > 12 && sel < 45)
                sel = 60;
            if (sel < 45)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, MAXLEN)
                                                   : $urandom_range(1, 8);
                push_words(room_left(len), 1'b1);
            end
            else if (sel < 80)
                pop_cmd();
            else if (sel < 92)
                push_words(room_left($urandom_range(1, 6)), 1'b0);
            else
                send_cmd(vlfs_pkg::ACT_PUSH, $urandom, 1'($urandom_range(0, 1)));
        end
        start <= 1'b0;

        // let outstanding pops finish
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d pops (%0d on an empty stack)",
                 sb.commands, sb.pops, sb.empty_pops);
        $display("%0d result beats checked, %0d pushed words dropped",
                 sb.beats, sb.dropped);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
